// File: rtl/uv_sphere_point_generator_assert.svh
// ----------------------------------------------------------------------------
// uv sphere point generator assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef UV_SPHERE_POINT_GENERATOR_ASSERT_SVH
`define UV_SPHERE_POINT_GENERATOR_ASSERT_SVH

// same-cycle implication, off during reset
`define UVS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("uvs assertion failed");

// next-cycle implication, off during reset
`define UVS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("uvs assertion failed");

// next-cycle implication that also covers reset
`define UVS_ASSERT_RST(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("uvs reset assertion failed");

`endif

// File: rtl/uvs_pkg.sv
// ----------------------------------------------------------------------------
// uvs_pkg
// constants, types and helper functions of the uv sphere point generator
// ----------------------------------------------------------------------------
package uvs_pkg;

   localparam int MAX_GRID_SIDE = 256;
   localparam int CNT_W         = 9;
   localparam int IDX_W         = 8;

   // long division: quotient bits retired per pipeline stage
   localparam int DIV_W      = 28;
   localparam int DIV_BITS   = 4;
   localparam int DIV_STAGES = DIV_W / DIV_BITS;
   localparam int DEN_W      = 9;

   localparam int CORDIC_STEPS   = 16;
   localparam int CORDIC_STAGES  = 8;
   localparam int CORDIC_PER_ST  = CORDIC_STEPS / CORDIC_STAGES;
   localparam int CW             = 32;
   localparam int PHASE_W        = 17;

   localparam logic signed [CW-1:0] CORDIC_GAIN = 32'sd652032874;

   localparam logic [CW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
   };

   localparam logic [1:0] CSR_RADIUS      = 2'd0;
   localparam logic [1:0] CSR_STACK_COUNT = 2'd1;
   localparam logic [1:0] CSR_SLICE_COUNT = 2'd2;

   localparam int POS_LIMIT  = 65535;
   localparam int NORM_LIMIT = 16384;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
   } cordic_type;

   typedef struct packed {
      logic [DEN_W-1:0]    rem;
      logic [DIV_BITS-1:0] q;
   } div_step_type;

   typedef struct packed {
      logic        quad_valid;
      logic [15:0] base_index;
      logic [16:0] tex_u;
      logic [16:0] tex_v;
      logic [24:0] tiled_u;
      logic [24:0] tiled_v;
   } side_type;

   // restoring division over a few numerator bits
   function automatic div_step_type div_step(input logic [DEN_W-1:0] rem,
                                             input logic [DIV_BITS-1:0] nib,
                                             input logic [DEN_W-1:0] den);
      div_step_type r;
      logic [DEN_W:0] t;
      r.rem = rem;
      r.q   = '0;
      for (int i = DIV_BITS - 1; i >= 0; i--) begin
         t = {r.rem, nib[i]};
         if (t >= {1'b0, den}) begin
            t      = t - {1'b0, den};
            r.q[i] = 1'b1;
         end
         r.rem = t[DEN_W-1:0];
      end
      return r;
   endfunction

   function automatic cordic_type cordic_iter(input cordic_type a, input int k);
      cordic_type r;
      logic signed [CW-1:0] ax, ay, az, dx, dy, at;
      ax = a.x;
      ay = a.y;
      az = a.z;
      dx = ay >>> k;
      dy = ax >>> k;
      at = $signed(ATAN_TAB[k]);
      if (!az[CW-1]) begin
         r.x = ax - dx;
         r.y = ay + dy;
         r.z = az - at;
      end else begin
         r.x = ax + dx;
         r.y = ay - dy;
         r.z = az + at;
      end
      return r;
   endfunction

   // round half up by 2^16, clamp to the normal range
   function automatic logic signed [15:0] sat_norm(input logic signed [32:0] v);
      logic signed [32:0] t;
      t = (v + 33'sd32768) >>> 16;
      if (t > 33'sd16384) return 16'sd16384;
      if (t < -33'sd16384) return -16'sd16384;
      return t[15:0];
   endfunction

   // round half up by 2^30, clamp to the position range
   function automatic logic signed [16:0] sat_pos(input logic signed [49:0] v);
      logic signed [49:0] t;
      t = (v + 50'sd536870912) >>> 30;
      if (t > 50'sd65535) return 17'sd65535;
      if (t < -50'sd65535) return -17'sd65535;
      return t[16:0];
   endfunction

endpackage

// File: rtl/uvs_divider.sv
// ----------------------------------------------------------------------------
// uvs_divider
// pipelined restoring divider, a few quotient bits per stage
// ----------------------------------------------------------------------------
module uvs_divider (
   input  logic                         clock,
   input  logic                         en,
   input  logic [uvs_pkg::DIV_W-1:0]    num,
   input  logic [uvs_pkg::DEN_W-1:0]    den,
   output logic [uvs_pkg::DIV_W-1:0]    quo
);

   localparam int NS = uvs_pkg::DIV_STAGES;
   localparam int NB = uvs_pkg::DIV_BITS;
   localparam int NW = uvs_pkg::DIV_W;

   logic [uvs_pkg::DEN_W-1:0] rem_ff [NS-1];
   logic [uvs_pkg::DEN_W-1:0] rem_in [NS-1];
   logic [NW-1:0]             num_ff [NS-1];
   logic [NW-1:0]             num_in [NS-1];
   logic [NW-1:0]             q_ff   [NS];
   logic [NW-1:0]             q_in   [NS];

   for (genvar g = 0; g < NS; g++) begin : g_stage
      logic [uvs_pkg::DEN_W-1:0] rem_src;
      logic [NW-1:0]             num_src;
      logic [NW-1:0]             q_src;
      uvs_pkg::div_step_type     step;

      if (g == 0) begin : g_first
         assign rem_src = '0;
         assign num_src = num;
         assign q_src   = '0;
      end else begin : g_rest
         assign rem_src = rem_ff[g-1];
         assign num_src = num_ff[g-1];
         assign q_src   = q_ff[g-1];
      end

      assign step    = uvs_pkg::div_step(rem_src, num_src[NW-1 -: NB], den);
      assign q_in[g] = {q_src[NW-NB-1:0], step.q};

      if (g < NS - 1) begin : g_carry
         assign rem_in[g] = step.rem;
         assign num_in[g] = num_src << NB;
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[g] <= rem_in[g];
               num_ff[g] <= num_in[g];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[g] <= q_in[g];
         end
      end
   end

   assign quo = q_ff[NS-1];

endmodule

// File: rtl/uvs_cordic.sv
// ----------------------------------------------------------------------------
// uvs_cordic
// pipelined rotation cordic, phase in 2^-17 turn to cosine and sine in q1.30
// ----------------------------------------------------------------------------
module uvs_cordic (
   input  logic                               clock,
   input  logic                               en,
   input  logic [uvs_pkg::PHASE_W-1:0]        phase,
   output logic signed [uvs_pkg::CW-1:0]      cos_out,
   output logic signed [uvs_pkg::CW-1:0]      sin_out
);

   localparam int NS = uvs_pkg::CORDIC_STAGES;
   localparam int NP = uvs_pkg::CORDIC_PER_ST;

   uvs_pkg::cordic_type st_ff   [NS];
   uvs_pkg::cordic_type st_in   [NS];
   logic [1:0]          quad_ff [NS];
   uvs_pkg::cordic_type init;

   assign init.x = uvs_pkg::CORDIC_GAIN;
   assign init.y = '0;
   assign init.z = {2'b00, phase[14:0], 15'b0};

   for (genvar g = 0; g < NS; g++) begin : g_stage
      uvs_pkg::cordic_type src;
      logic [1:0]          quad_src;

      if (g == 0) begin : g_first
         assign src      = init;
         assign quad_src = phase[16:15];
      end else begin : g_rest
         assign src      = st_ff[g-1];
         assign quad_src = quad_ff[g-1];
      end

      always_comb begin
         uvs_pkg::cordic_type t;
         t = src;
         for (int j = 0; j < NP; j++) begin
            t = uvs_pkg::cordic_iter(t, g * NP + j);
         end
         st_in[g] = t;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[g]   <= st_in[g];
            quad_ff[g] <= quad_src;
         end
      end
   end

   // quadrant fold-out
   always_comb begin
      case (quad_ff[NS-1])
         2'd0: begin
            cos_out = st_ff[NS-1].x;
            sin_out = st_ff[NS-1].y;
         end
         2'd1: begin
            cos_out = -st_ff[NS-1].y;
            sin_out = st_ff[NS-1].x;
         end
         2'd2: begin
            cos_out = -st_ff[NS-1].x;
            sin_out = -st_ff[NS-1].y;
         end
         default: begin
            cos_out = st_ff[NS-1].y;
            sin_out = -st_ff[NS-1].x;
         end
      endcase
   end

endmodule

// File: rtl/uv_sphere_point_generator.sv
// ----------------------------------------------------------------------------
// uv_sphere_point_generator
// throughput: one transaction per cycle while the response is not stalled, through the fully
//   pipelined divider (7 stages), cordic (8 stages) and two multiply stages
// a response stall freezes the whole pipeline; synchronous reset clears all
//   valid bits and loads radius 256, stack count 16, slice count 32
// ----------------------------------------------------------------------------
module uv_sphere_point_generator (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [1:0]                csr_index,
   input  logic [15:0]               csr_write_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [uvs_pkg::IDX_W-1:0] req_stack_index,
   input  logic [uvs_pkg::IDX_W-1:0] req_slice_index,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [16:0]        rsp_pos_x,
   output logic signed [16:0]        rsp_pos_y,
   output logic signed [16:0]        rsp_pos_z,
   output logic signed [15:0]        rsp_normal_x,
   output logic signed [15:0]        rsp_normal_y,
   output logic signed [15:0]        rsp_normal_z,
   output logic [16:0]               rsp_tex_u,
   output logic [16:0]               rsp_tex_v,
   output logic [24:0]               rsp_tiled_u,
   output logic [24:0]               rsp_tiled_v,
   output logic                      rsp_quad_valid,
   output logic [15:0]               rsp_base_index
);

   localparam int CNT_W   = uvs_pkg::CNT_W;
   localparam int DW      = uvs_pkg::DIV_W;
   localparam int NSTAGES = uvs_pkg::DIV_STAGES + uvs_pkg::CORDIC_STAGES + 3;
   localparam int TEX_ST  = uvs_pkg::DIV_STAGES;
   localparam int OUT_ST  = NSTAGES - 1;

   logic [15:0]      radius_ff;
   logic [CNT_W-1:0] stack_count_ff;
   logic [CNT_W-1:0] slice_count_ff;

   logic [NSTAGES-1:0] valid_ff;
   logic               en;

   uvs_pkg::side_type side_ff [NSTAGES];
   uvs_pkg::side_type side_in [NSTAGES];

   logic [CNT_W-1:0] stack_eff, slice_eff, stack_dm1, slice_dm1;
   logic [DW-1:0]    num_phi, num_u, num_v, q_phi, q_u, q_v;
   logic [33:0]      tiled_u_full, tiled_v_full;

   logic signed [31:0] cphi, sphi, cth, sth;
   logic signed [63:0] p_sx_ff, p_sx_in, p_cx_ff, p_cx_in;
   logic signed [31:0] cth_ff;
   logic signed [32:0] dx, dy, dz;
   logic signed [16:0] r_s;
   logic signed [49:0] px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic signed [15:0] nx_m2_ff, ny_m2_ff, nz_m2_ff;
   logic signed [15:0] nx_ff, ny_ff, nz_ff;
   logic signed [16:0] pos_x_ff, pos_y_ff, pos_z_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff      <= 16'd256;
         stack_count_ff <= 9'd16;
         slice_count_ff <= 9'd32;
      end else if (csr_write_enable) begin
         case (csr_index)
            uvs_pkg::CSR_RADIUS:      radius_ff      <= csr_write_data;
            uvs_pkg::CSR_STACK_COUNT: stack_count_ff <= csr_write_data[CNT_W-1:0];
            uvs_pkg::CSR_SLICE_COUNT: slice_count_ff <= csr_write_data[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (stack_count_ff < 9'd2) stack_eff = 9'd2;
      else if (stack_count_ff > CNT_W'(uvs_pkg::MAX_GRID_SIDE))
         stack_eff = CNT_W'(uvs_pkg::MAX_GRID_SIDE);
      else stack_eff = stack_count_ff;
      if (slice_count_ff < 9'd2) slice_eff = 9'd2;
      else if (slice_count_ff > CNT_W'(uvs_pkg::MAX_GRID_SIDE))
         slice_eff = CNT_W'(uvs_pkg::MAX_GRID_SIDE);
      else slice_eff = slice_count_ff;
   end

   assign stack_dm1 = stack_eff - 9'd1;
   assign slice_dm1 = slice_eff - 9'd1;

   // whole pipeline holds while the response is stalled
   assign en        = !(valid_ff[OUT_ST] && rsp_stall);
   assign req_stall = valid_ff[OUT_ST] && rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[NSTAGES-2:0], req_valid};
      end
   end

   // round(n * 2^sh / d) as (n * 2^(sh+1) + d) / 2d
   assign num_phi = {2'b00, req_slice_index, 18'b0} + DW'(slice_dm1);
   assign num_u   = {3'b000, req_slice_index, 17'b0} + DW'(slice_dm1);
   assign num_v   = {3'b000, req_stack_index, 17'b0} + DW'(stack_dm1);

   uvs_divider u_div_phi (
      .clock (clock), .en (en), .num (num_phi),
      .den   ({slice_dm1[7:0], 1'b0}), .quo (q_phi)
   );

   uvs_divider u_div_u (
      .clock (clock), .en (en), .num (num_u),
      .den   ({slice_dm1[7:0], 1'b0}), .quo (q_u)
   );

   uvs_divider u_div_v (
      .clock (clock), .en (en), .num (num_v),
      .den   ({stack_dm1[7:0], 1'b0}), .quo (q_v)
   );

   uvs_cordic u_cordic_phi (
      .clock (clock), .en (en), .phase (q_phi[uvs_pkg::PHASE_W-1:0]),
      .cos_out (cphi), .sin_out (sphi)
   );

   uvs_cordic u_cordic_theta (
      .clock (clock), .en (en), .phase (q_v[uvs_pkg::PHASE_W-1:0]),
      .cos_out (cth), .sin_out (sth)
   );

   assign tiled_u_full = 34'(slice_eff) * 34'(q_u[24:0]);
   assign tiled_v_full = 34'(stack_eff) * 34'(q_v[24:0]);

   // side data rides next to the arithmetic
   always_comb begin
      logic [CNT_W-1:0] st1, sl1;
      logic [16:0]      base_full;
      st1       = {1'b0, req_stack_index} + 9'd1;
      sl1       = {1'b0, req_slice_index} + 9'd1;
      base_full = 17'(req_stack_index) * 17'(slice_eff) + 17'(req_slice_index);
      side_in[0]            = '0;
      side_in[0].quad_valid = (st1 < stack_eff) && (sl1 < slice_eff);
      side_in[0].base_index = base_full[15:0];
      for (int k = 1; k < NSTAGES; k++) begin
         side_in[k] = side_ff[k-1];
      end
      side_in[TEX_ST].tex_u   = (q_u > DW'(65536)) ? 17'd65536 : q_u[16:0];
      side_in[TEX_ST].tex_v   = (q_v > DW'(65536)) ? 17'd65536 : q_v[16:0];
      side_in[TEX_ST].tiled_u = (tiled_u_full > 34'd16777216) ? 25'd16777216
                                                              : tiled_u_full[24:0];
      side_in[TEX_ST].tiled_v = (tiled_v_full > 34'd16777216) ? 25'd16777216
                                                              : tiled_v_full[24:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= side_in;
      end
   end

   // direction products
   assign p_sx_in = sphi * sth;
   assign p_cx_in = cphi * sth;

   // direction rounded to q1.30, then scaled by the radius
   assign dx  = 33'((p_sx_ff + 64'sd536870912) >>> 30);
   assign dz  = 33'((p_cx_ff + 64'sd536870912) >>> 30);
   assign dy  = $signed({cth_ff[31], cth_ff});
   assign r_s = $signed({1'b0, radius_ff});
   assign px_in = dx * r_s;
   assign py_in = dy * r_s;
   assign pz_in = dz * r_s;

   always_ff @(posedge clock) begin
      if (en) begin
         p_sx_ff  <= p_sx_in;
         p_cx_ff  <= p_cx_in;
         cth_ff   <= cth;
         px_ff    <= px_in;
         py_ff    <= py_in;
         pz_ff    <= pz_in;
         nx_m2_ff <= uvs_pkg::sat_norm(dx);
         ny_m2_ff <= uvs_pkg::sat_norm(dy);
         nz_m2_ff <= uvs_pkg::sat_norm(dz);
         nx_ff    <= nx_m2_ff;
         ny_ff    <= ny_m2_ff;
         nz_ff    <= nz_m2_ff;
         pos_x_ff <= uvs_pkg::sat_pos(px_ff);
         pos_y_ff <= uvs_pkg::sat_pos(py_ff);
         pos_z_ff <= uvs_pkg::sat_pos(pz_ff);
      end
   end

   assign rsp_valid      = valid_ff[OUT_ST];
   assign rsp_pos_x      = pos_x_ff;
   assign rsp_pos_y      = pos_y_ff;
   assign rsp_pos_z      = pos_z_ff;
   assign rsp_normal_x   = nx_ff;
   assign rsp_normal_y   = ny_ff;
   assign rsp_normal_z   = nz_ff;
   assign rsp_tex_u      = side_ff[OUT_ST].tex_u;
   assign rsp_tex_v      = side_ff[OUT_ST].tex_v;
   assign rsp_tiled_u    = side_ff[OUT_ST].tiled_u;
   assign rsp_tiled_v    = side_ff[OUT_ST].tiled_v;
   assign rsp_quad_valid = side_ff[OUT_ST].quad_valid;
   assign rsp_base_index = side_ff[OUT_ST].base_index;

endmodule

// File: rtl/uvs_checker.sv
// ----------------------------------------------------------------------------
// uvs_checker
// port-level assertions for the uv sphere point generator
// ----------------------------------------------------------------------------
`include "uv_sphere_point_generator_assert.svh"

module uvs_checker (
   input logic               clock,
   input logic               reset,
   input logic               csr_write_enable,
   input logic [1:0]         csr_index,
   input logic [15:0]        csr_write_data,
   input logic               req_valid,
   input logic               req_stall,
   input logic [7:0]         req_stack_index,
   input logic [7:0]         req_slice_index,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [16:0] rsp_pos_x,
   input logic signed [16:0] rsp_pos_y,
   input logic signed [16:0] rsp_pos_z,
   input logic signed [15:0] rsp_normal_x,
   input logic signed [15:0] rsp_normal_y,
   input logic signed [15:0] rsp_normal_z,
   input logic [16:0]        rsp_tex_u,
   input logic [16:0]        rsp_tex_v,
   input logic [24:0]        rsp_tiled_u,
   input logic [24:0]        rsp_tiled_v,
   input logic               rsp_quad_valid,
   input logic [15:0]        rsp_base_index
);

   // reset empties the pipeline
   `UVS_ASSERT_RST(a_reset_empty, clock, reset, !rsp_valid)

   // the request side only stalls behind a stalled response
   `UVS_ASSERT_IMP(a_stall_source, clock, reset, req_stall, rsp_valid && rsp_stall)

   // a stalled response stays valid and holds its pos x, normal y and base index
   `UVS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_pos_x) && $stable(rsp_normal_y) && $stable(rsp_base_index))

   // normal x and tex u stay in range
   `UVS_ASSERT_IMP(a_norm_range, clock, reset, rsp_valid, rsp_normal_x <= 16'sd16384 && rsp_normal_x >= -16'sd16384 && rsp_tex_u <= 17'd65536)

endmodule

bind uv_sphere_point_generator uvs_checker u_uvs_checker (.*);
